/* hdl/assert_macros.svh */
// assertion macros included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mhpq_pkg.sv */
// types and codes shared by the max-heap priority queue files
package mhpq_pkg;

    localparam int KEY_W     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;

    // request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // response status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

endpackage

/* hdl/mhpq_if.sv */
// request and response channel interfaces of the priority queue

interface mhpq_cmd_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [mhpq_pkg::KEY_W-1:0]     key;
    logic [mhpq_pkg::PAYLOAD_W-1:0] payload;

    modport source (output valid, output opcode, output key, output payload, input ready);
    modport sink   (input valid, input opcode, input key, input payload, output ready);
endinterface

interface mhpq_rsp_if #(
    parameter int CNT_W = 5
);
    logic                           valid;
    logic                           ready;
    logic [mhpq_pkg::STATUS_W-1:0]  status;
    logic [mhpq_pkg::KEY_W-1:0]     out_key;
    logic [mhpq_pkg::PAYLOAD_W-1:0] out_payload;
    logic [CNT_W-1:0]               count;

    modport source (output valid, output status, output out_key, output out_payload,
                    output count, input ready);
    modport sink   (input valid, input status, input out_key, input out_payload,
                    input count, output ready);
endinterface

/* hdl/mhpq_ram.sv */
// generic simple dual-port ram, one write port, one registered read port
module mhpq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/max_heap_priority_queue_unit.sv */
// max-heap priority queue: one entry ram, a search scan and a sift-down sequencer
// one request at a time; a search reads the entries in index order until a hit or the last entry
// rebuild: per internal node a load step, per level left, right and compare steps, a leaf write
// an insert when empty or full, or a remove when empty, goes straight to the finish state
// the response is registered, loaded in the finish state once the response register is free
// reset clears fill count, state and response valid; the entry ram is not cleared
module max_heap_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    mhpq_cmd_if.sink          cmd,
    mhpq_rsp_if.source        rsp
);

    // address, count, child index and entry widths
    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IW    = AW + 2;
    localparam int EW    = $bits(mhpq_pkg::entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LAST_RD,
        ST_LAST_WR,
        ST_LOAD,
        ST_STEP_L,
        ST_STEP_R,
        ST_STEP_C,
        ST_FINISH
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [mhpq_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [CNT_W-1:0]              scan_reg, scan_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]              pend_idx_reg, pend_idx_next;
    logic [AW-1:0]                 found_reg, found_next;
    logic [AW-1:0]                 node_reg, node_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic                          load_reg, load_next;
    mhpq_pkg::entry_t              carried_reg, carried_next;
    mhpq_pkg::entry_t              left_reg, left_next;
    logic [mhpq_pkg::STATUS_W-1:0] status_reg, status_next;
    mhpq_pkg::entry_t              removed_reg, removed_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mhpq_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    mhpq_pkg::entry_t              out_entry_reg, out_entry_next;
    logic [CNT_W-1:0]              out_count_reg, out_count_next;

    // ram port
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    mhpq_pkg::entry_t              ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [EW-1:0]                 ram_rdata;
    mhpq_pkg::entry_t              rd_entry;

    // sift step helpers
    logic [IW-1:0]                 left_idx;
    logic [IW-1:0]                 right_idx;
    logic [IW-1:0]                 fill_wide;
    logic [CNT_W-1:0]              fill_inc;
    logic [CNT_W-1:0]              fill_dec;
    mhpq_pkg::entry_t              cur_entry;
    logic                          left_wins;
    logic                          right_wins;
    logic [mhpq_pkg::KEY_W-1:0]    best_key;
    logic                          sift_done;

    mhpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = mhpq_pkg::entry_t'(ram_rdata);
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + IW'(1);
    assign fill_wide = IW'(fill_reg);
    assign fill_inc  = fill_reg + CNT_W'(1);
    assign fill_dec  = fill_reg - CNT_W'(1);

    // the carried entry arrives from the ram on the first step of a sift
    assign cur_entry  = load_reg ? rd_entry : carried_reg;
    // left child must beat the carried key, right child must beat the winner so far
    assign left_wins  = left_reg.key > carried_reg.key;
    assign best_key   = left_wins ? left_reg.key : carried_reg.key;
    assign right_wins = (right_idx < fill_wide) && (rd_entry.key > best_key);

    // request side only opens when the sequencer is idle
    assign cmd.ready       = (state_reg == ST_IDLE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.out_key     = out_entry_reg.key;
    assign rsp.out_payload = out_entry_reg.payload;
    assign rsp.count       = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        key_next        = key_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        node_next       = node_reg;
        pos_next        = pos_reg;
        load_next       = load_reg;
        carried_next    = carried_reg;
        left_next       = left_reg;
        status_next     = status_reg;
        removed_next    = removed_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = carried_reg;
        ram_raddr       = node_reg;
        sift_done       = 1'b0;

        // response taken downstream
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    key_next     = cmd.key;
                    removed_next = '0;
                    status_next  = mhpq_pkg::STATUS_OK;
                    if (cmd.opcode == mhpq_pkg::OP_INSERT)
                    begin
                        if (fill_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = mhpq_pkg::STATUS_FULL;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            // append at the tail, then rebuild unless it is the only entry
                            ram_we    = 1'b1;
                            ram_waddr = fill_reg[AW-1:0];
                            ram_wdata = '{key: cmd.key, payload: cmd.payload};
                            fill_next = fill_inc;
                            if (fill_reg == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                node_next  = AW'((fill_inc >> 1) - CNT_W'(1));
                                state_next = ST_LOAD;
                            end
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = mhpq_pkg::STATUS_ABSENT;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            scan_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SEARCH;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                // one read issued per cycle, the key compare on each read follows in the next cycle
                ram_raddr       = (scan_reg < fill_reg) ? scan_reg[AW-1:0] : '0;
                scan_next       = scan_reg + CNT_W'(1);
                pend_valid_next = 1'b1;
                pend_idx_next   = scan_reg;
                if (pend_valid_reg)
                begin
                    if (rd_entry.key == key_reg)
                    begin
                        found_next   = pend_idx_reg[AW-1:0];
                        removed_next = rd_entry;
                        state_next   = ST_LAST_RD;
                    end
                    else if (pend_idx_reg == fill_dec)
                    begin
                        status_next = mhpq_pkg::STATUS_ABSENT;
                        state_next  = ST_FINISH;
                    end
                end
            end

            ST_LAST_RD:
            begin
                ram_raddr  = fill_dec[AW-1:0];
                state_next = ST_LAST_WR;
            end

            ST_LAST_WR:
            begin
                // last entry fills the hole left by the removed one
                ram_we    = 1'b1;
                ram_waddr = found_reg;
                ram_wdata = rd_entry;
                fill_next = fill_dec;
                if (fill_dec < CNT_W'(2))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    node_next  = AW'((fill_dec >> 1) - CNT_W'(1));
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                ram_raddr  = node_reg;
                pos_next   = node_reg;
                load_next  = 1'b1;
                state_next = ST_STEP_L;
            end

            ST_STEP_L:
            begin
                carried_next = cur_entry;
                load_next    = 1'b0;
                if (left_idx >= fill_wide)
                begin
                    // leaf reached: carried entry settles here
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = cur_entry;
                    sift_done = 1'b1;
                end
                else
                begin
                    ram_raddr  = left_idx[AW-1:0];
                    state_next = ST_STEP_R;
                end
            end

            ST_STEP_R:
            begin
                left_next = rd_entry;
                if (right_idx < fill_wide)
                begin
                    ram_raddr = right_idx[AW-1:0];
                end
                state_next = ST_STEP_C;
            end

            ST_STEP_C:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                priority if (right_wins)
                begin
                    ram_wdata  = rd_entry;
                    pos_next   = right_idx[AW-1:0];
                    state_next = ST_STEP_L;
                end
                else if (left_wins)
                begin
                    ram_wdata  = left_reg;
                    pos_next   = left_idx[AW-1:0];
                    state_next = ST_STEP_L;
                end
                else
                begin
                    ram_wdata = carried_reg;
                    sift_done = 1'b1;
                end
            end

            ST_FINISH:
            begin
                // wait for the response register to be free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_entry_next  = removed_reg;
                    out_count_next  = fill_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // move on to the next internal node toward the root
        if (sift_done)
        begin
            if (node_reg == '0)
            begin
                state_next = ST_FINISH;
            end
            else
            begin
                node_next  = node_reg - AW'(1);
                state_next = ST_LOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            key_reg        <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            found_reg      <= '0;
            node_reg       <= '0;
            pos_reg        <= '0;
            load_reg       <= 1'b0;
            carried_reg    <= '0;
            left_reg       <= '0;
            status_reg     <= mhpq_pkg::STATUS_OK;
            removed_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= mhpq_pkg::STATUS_OK;
            out_entry_reg  <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            key_reg        <= key_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            found_reg      <= found_next;
            node_reg       <= node_next;
            pos_reg        <= pos_next;
            load_reg       <= load_next;
            carried_reg    <= carried_next;
            left_reg       <= left_next;
            status_reg     <= status_next;
            removed_reg    <= removed_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_entry_reg  <= out_entry_next;
            out_count_reg  <= out_count_next;
        end
    end

endmodule

/* hdl/mhpq_checker.sv */
// port-level checker for the priority queue and its bind
`include "assert_macros.svh"

module mhpq_checker #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [mhpq_pkg::STATUS_W-1:0]  rsp_status,
    input logic [mhpq_pkg::KEY_W-1:0]     rsp_out_key,
    input logic [mhpq_pkg::PAYLOAD_W-1:0] rsp_out_payload,
    input logic [CNT_W-1:0]               rsp_count
);

    // one request at a time: busy right after a request is taken
    `ASSERT_CLK(a_busy_after_req, clk, rst_n, (cmd_valid && cmd_ready) |=> !cmd_ready, "accepted a request back to back")

    // a valid response always carries one of the defined status codes
    `ASSERT_CLK(a_status_code, clk, rst_n, rsp_valid |-> (rsp_status == mhpq_pkg::STATUS_OK || rsp_status == mhpq_pkg::STATUS_FULL || rsp_status == mhpq_pkg::STATUS_ABSENT), "undefined status code")

    // failed requests carry no entry
    `ASSERT_CLK(a_fail_zero, clk, rst_n, (rsp_valid && rsp_status != mhpq_pkg::STATUS_OK) |-> (rsp_out_key == '0 && rsp_out_payload == '0), "entry data on a failed request")

    // count never exceeds the capacity
    `ASSERT_CLK(a_count_range, clk, rst_n, rsp_valid |-> (rsp_count <= CNT_W'(CAPACITY)), "count beyond capacity")

    // stalled response holds its status, count and key
    `ASSERT_CLK(a_rsp_hold, clk, rst_n, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_out_key)), "stalled response changed")

endmodule

bind max_heap_priority_queue_unit mhpq_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_mhpq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_out_key     (rsp.out_key),
    .rsp_out_payload (rsp.out_payload),
    .rsp_count       (rsp.count)
);
